// ===== src/text_console_writer_core_assert.svh =====
// Assertion macros for the text console writer.
// Both sample on i_clk and are held off while i_rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication
`define TCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication
`define TCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

// ===== src/tcw_pkg.sv =====
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int COLOUR_W = 4;
    localparam int CELL_W   = ATTR_W + CHAR_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    // Register indexes on the APB port
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // latch command word, reset sweep counter
        logic put;          // apply put at cursor
        logic home;         // home cursor for clear
        logic clr_step;     // blank one cell of the clear sweep
        logic scr_step;     // one step of the scroll sweep
        logic emit;         // present the result word
        logic emit_scroll;  // result word carries the scroll flag
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic need_scroll;
        logic sweep_last;
    } t_dp_stat;

endpackage

// ===== src/text_console_writer_core.sv =====
// Put, read and unused commands: the accepting edge moves the controller to its execute
// state, which raises emit; the result strobe is registered from emit, and busy drops with it.
// Clear: one screen cell blanked per cycle through the single write port.
// Put that scrolls: one cell copied or blanked per cycle, write port bound.
// Reset: cursor at row 0 column 0, foreground 15, background 0; screen undefined until cleared.
// The result is shown for exactly one cycle on o_result_valid; the receiver cannot stall.
module text_console_writer_core import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_column,
    // result channel
    output logic              o_result_valid,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [CHAR_W-1:0] o_cell_character,
    output logic [ATTR_W-1:0] o_cell_attribute,
    output logic              o_did_scroll,
    // APB register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    `include "text_console_writer_core_assert.svh"

    logic [COLOUR_W-1:0] r_fg;
    logic [COLOUR_W-1:0] r_bg;
    logic                reg_wr;
    t_dp_cmd             ctl;
    t_dp_stat            stat;

    // Colour registers
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd15;
            r_bg <= 4'd0;
        end else if (reg_wr) begin
            if (paddr[2] == REG_FG) begin
                r_fg <= pwdata[COLOUR_W-1:0];
            end
            if (paddr[2] == REG_BG) begin
                r_bg <= pwdata[COLOUR_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    tcw_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .i_cmd            (i_cmd),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_column    (i_read_column),
        .i_attr           ({r_bg, r_fg}),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_did_scroll     (o_did_scroll),
        .o_result_valid   (o_result_valid)
    );

    // Checks
    `TCW_ASSERT_IMP(a_result_when_free, o_result_valid, !busy)
    `TCW_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
    `TCW_ASSERT_NXT(a_single_strobe, o_result_valid, !o_result_valid)
    `TCW_ASSERT_NXT(a_read_latency, start && !busy && (i_cmd == CMD_READ), ##1 o_result_valid)
    `TCW_ASSERT_IMP(a_scroll_last_row, o_did_scroll, o_result_valid && (o_cursor_row == ROW_W'(ROWS - 1)))

endmodule

// ===== src/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_SCROLL,
        S_SCROLL_END
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_busy;
    t_dp_cmd ctl;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    ctl.accept = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_put) begin
                    ctl.put = 1'b1;
                    if (i_stat.need_scroll) begin
                        n_state = S_SCROLL;
                    end else begin
                        ctl.emit = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.is_clear) begin
                    ctl.home = 1'b1;
                    n_state  = S_CLEAR;
                end else begin
                    ctl.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (i_stat.sweep_last) begin
                    ctl.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SCROLL: begin
                ctl.scr_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_SCROLL_END;
                end
            end
            S_SCROLL_END: begin
                // last copied/blank word lands in this cycle
                ctl.emit        = 1'b1;
                ctl.emit_scroll = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_ctl  = ctl;
    assign o_busy = r_busy;

endmodule

// ===== src/tcw_dpath.sv =====
module tcw_dpath import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_ctl,
    output t_dp_stat          o_stat,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_column,
    input  logic [ATTR_W-1:0] i_attr,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [CHAR_W-1:0] o_cell_character,
    output logic [ATTR_W-1:0] o_cell_attribute,
    output logic              o_did_scroll,
    output logic              o_result_valid
);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END_A  = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_A      = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_X      = (ROW_W + 1)'(ROWS);

    // Screen store
    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    // Latched command word
    logic [CMD_W-1:0]  r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic              r_rd_ok;

    // Cursor and sweep
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_lag_we;
    logic [ADDR_W-1:0] r_lag_addr;
    logic              r_lag_copy;

    // Result registers
    logic              r_valid;
    logic              r_did_scroll;
    logic [CHAR_W-1:0] r_cell_ch;
    logic [ATTR_W-1:0] r_cell_attr;

    // Put decode
    logic              put_we;
    logic [COL_W-1:0]  put_col;
    logic [COL_W-1:0]  put_addr_col;
    logic [ROW_W:0]    put_row_x;
    logic [ROW_W:0]    row_inc;
    logic [CELL_W-1:0] put_data;
    logic [ADDR_W-1:0] put_addr;
    logic              need_scroll;
    logic [CELL_W-1:0] blank;
    logic [ADDR_W-1:0] in_addr;

    assign blank   = {i_attr, CH_BLANK};
    assign row_inc = {1'b0, r_row} + 1'b1;

    // Cursor movement and cell write for one put
    always_comb begin
        put_we       = 1'b0;
        put_col      = r_col;
        put_addr_col = r_col;
        put_row_x    = {1'b0, r_row};
        put_data     = {i_attr, r_char};
        case (r_char)
            CH_NEWLINE: begin
                put_col   = '0;
                put_row_x = row_inc;
            end
            CH_RETURN: begin
                put_col = '0;
            end
            CH_BACKSPACE: begin
                // no effect at the row start
                if (r_col != '0) begin
                    put_col      = r_col - 1'b1;
                    put_addr_col = r_col - 1'b1;
                    put_we       = 1'b1;
                    put_data     = blank;
                end
            end
            default: begin
                put_we = 1'b1;
                if (r_col == LAST_COL) begin
                    put_col   = '0;
                    put_row_x = row_inc;
                end else begin
                    put_col = r_col + 1'b1;
                end
            end
        endcase
    end

    assign need_scroll = (put_row_x == ROWS_X);
    assign put_addr    = ADDR_W'(r_row) * COLS_A + ADDR_W'(put_addr_col);
    assign in_addr     = ADDR_W'(i_read_row) * COLS_A + ADDR_W'(i_read_column);

    // Write port: scroll lag stage, clear sweep, or put
    always_comb begin
        mem_we = 1'b0;
        mem_wa = put_addr;
        mem_wd = put_data;
        if (r_lag_we) begin
            mem_we = 1'b1;
            mem_wa = r_lag_addr;
            mem_wd = r_lag_copy ? r_rd_data : blank;
        end else if (i_ctl.clr_step) begin
            mem_we = 1'b1;
            mem_wa = r_cnt;
            mem_wd = blank;
        end else if (i_ctl.put) begin
            mem_we = put_we;
        end
    end

    // Read port: one row ahead during scroll, else the requested cell
    assign mem_ra = i_ctl.scr_step ? (r_cnt + COLS_A) : in_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // Command word latch and scroll lag stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_char  <= i_char_code;
            r_rd_ok <= (i_read_row < ROW_W'(ROWS)) && (i_read_column < COL_W'(COLUMNS));
        end
        r_lag_addr <= r_cnt;
        r_lag_copy <= (r_cnt < COPY_END_A);
    end

    // Control state: cursor, sweep counter, lag enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_cnt    <= '0;
            r_lag_we <= 1'b0;
        end else begin
            r_lag_we <= i_ctl.scr_step;
            if (i_ctl.accept) begin
                r_cnt <= '0;
            end else if (i_ctl.clr_step || i_ctl.scr_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_ctl.home) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_ctl.put) begin
                r_col <= put_col;
                r_row <= need_scroll ? LAST_ROW : put_row_x[ROW_W-1:0];
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_did_scroll <= 1'b0;
        end else begin
            r_valid      <= i_ctl.emit;
            r_did_scroll <= i_ctl.emit_scroll;
        end
        if (i_ctl.emit) begin
            if ((r_cmd == CMD_READ) && r_rd_ok) begin
                r_cell_ch   <= r_rd_data[CHAR_W-1:0];
                r_cell_attr <= r_rd_data[CELL_W-1:CHAR_W];
            end else begin
                r_cell_ch   <= '0;
                r_cell_attr <= '0;
            end
        end
    end

    assign o_stat.is_put      = (r_cmd == CMD_PUT);
    assign o_stat.is_clear    = (r_cmd == CMD_CLEAR);
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.sweep_last  = (r_cnt == LAST_A);

    assign o_cursor_column  = r_col;
    assign o_cursor_row     = r_row;
    assign o_cell_character = r_cell_ch;
    assign o_cell_attribute = r_cell_attr;
    assign o_did_scroll     = r_did_scroll;
    assign o_result_valid   = r_valid;

endmodule
